@@ rtl/core/pidc_pkg.sv @@
package pidc_pkg;

  // Gain fraction bits: the weighted sum is shifted right by this amount.
  localparam int unsigned FRAC_BITS = 8;

  localparam int unsigned ERR_W    = 16;
  localparam int unsigned MEAS_W   = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned LIMIT_W  = 32;
  localparam int unsigned INTEG_W  = 32;
  localparam int unsigned CORR_W   = 32;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Measurement difference, proportional, integral and derivative product widths.
  localparam int unsigned DMEAS_W  = MEAS_W + 1;
  localparam int unsigned PROD_P_W = GAIN_W + ERR_W;
  localparam int unsigned PROD_I_W = GAIN_W + INTEG_W;
  localparam int unsigned PROD_D_W = GAIN_W + DMEAS_W;
  localparam int unsigned SUM_W    = PROD_I_W + 1;

  // Mode bit positions.
  localparam int unsigned MODE_CLAMP_INTEG = 0;
  localparam int unsigned MODE_ZERO_CROSS  = 1;
  localparam int unsigned MODE_CLAMP_OUT   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_LIMIT_LOW  = 3'd3,
    REG_LIMIT_HIGH = 3'd4,
    REG_MODE_BITS  = 3'd5
  } cfg_reg_t;

endpackage

@@ rtl/core/pid_controller_step_core.sv @@
// PID controller step, derivative on measurement, Q-format gains.
// An accepted input passes through the input register stage, then the result register.
// One transaction per cycle unless m_tready stalls; integrator update is combinational.
// Reset (rst, synchronous, active high): gains 0, limits full 32-bit range, mode 0,
// integrator, previous measurement and previous error cleared, pipeline emptied.
module pid_controller_step_core
  import pidc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // [15:0] err_sample, [31:16] measured
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata    // [31:0] correction
);

  // Configuration registers
  logic signed [GAIN_W-1:0]  prop_gain;
  logic signed [GAIN_W-1:0]  integ_gain;
  logic signed [GAIN_W-1:0]  deriv_gain;
  logic signed [LIMIT_W-1:0] limit_low;
  logic signed [LIMIT_W-1:0] limit_high;
  logic [MODE_W-1:0]         mode_bits;

  // Controller state, updated as each input transaction is accepted
  logic signed [INTEG_W-1:0] integrator;
  logic signed [MEAS_W-1:0]  prev_measured;
  logic signed [ERR_W-1:0]   prev_err;

  // Input register stage
  logic                      s1_valid;
  logic signed [ERR_W-1:0]   s1_err;
  logic signed [DMEAS_W-1:0] s1_dmeas;
  logic signed [INTEG_W-1:0] s1_integ;

  // Result register
  logic signed [CORR_W-1:0]  correction;

  logic signed [ERR_W-1:0]   err_in;
  logic signed [MEAS_W-1:0]  meas_in;
  logic                      s_accept;
  logic                      out_load;

  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_sat;
  logic signed [INTEG_W-1:0] integ_clamped;
  logic                      zero_cross;
  logic signed [INTEG_W-1:0] integrator_next;
  logic signed [DMEAS_W-1:0] dmeas_next;

  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  logic signed [PROD_D_W-1:0] prod_d;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    sum_shr;
  logic signed [CORR_W-1:0]   corr_sat;
  logic signed [CORR_W-1:0]   correction_next;

  localparam logic signed [SUM_W-1:0] SUM_MAX32 = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SUM_MIN32 = SUM_W'(-64'sd2147483648);

  // Upper bound wins first, so inverted limits give limit_high for large values.
  function automatic logic signed [LIMIT_W-1:0] clamp_lim(
    input logic signed [LIMIT_W-1:0] x,
    input logic signed [LIMIT_W-1:0] lo,
    input logic signed [LIMIT_W-1:0] hi
  );
    logic signed [LIMIT_W-1:0] r;
    if (x > hi) begin
      r = hi;
    end else if (x < lo) begin
      r = lo;
    end else begin
      r = x;
    end
    return r;
  endfunction

  assign err_in  = s_tdata[ERR_W-1:0];
  assign meas_in = s_tdata[ERR_W+MEAS_W-1:ERR_W];

  // The result register frees up when empty or when its transaction is taken;
  // the input stage moves on whenever it is empty or can hand off.
  assign out_load = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  // Integrator recurrence: saturating add, optional clamp, optional zero on sign change.
  always_comb begin
    integ_sum = (INTEG_W+1)'(integrator) + (INTEG_W+1)'(err_in);
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_sat = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                     : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_sat = integ_sum[INTEG_W-1:0];
    end

    integ_clamped = mode_bits[MODE_CLAMP_INTEG] ? clamp_lim(integ_sat, limit_low, limit_high)
                                                 : integ_sat;

    zero_cross = ((err_in > 0) && (prev_err <= 0)) || ((err_in < 0) && (prev_err >= 0));

    if (mode_bits[MODE_ZERO_CROSS] && zero_cross) begin
      integrator_next = '0;
    end else begin
      integrator_next = integ_clamped;
    end

    dmeas_next = DMEAS_W'(prev_measured) - DMEAS_W'(meas_in);
  end

  // Weighted sum, scale, saturate and optional output clamp.
  always_comb begin
    prod_p  = PROD_P_W'(prop_gain) * PROD_P_W'(s1_err);
    prod_i  = PROD_I_W'(integ_gain) * PROD_I_W'(s1_integ);
    prod_d  = PROD_D_W'(deriv_gain) * PROD_D_W'(s1_dmeas);
    sum     = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
    sum_shr = sum >>> FRAC_BITS;

    if (sum_shr > SUM_MAX32) begin
      corr_sat = SUM_MAX32[CORR_W-1:0];
    end else if (sum_shr < SUM_MIN32) begin
      corr_sat = SUM_MIN32[CORR_W-1:0];
    end else begin
      corr_sat = sum_shr[CORR_W-1:0];
    end

    correction_next = mode_bits[MODE_CLAMP_OUT] ? clamp_lim(corr_sat, limit_low, limit_high)
                                                : corr_sat;
  end

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= '0;
      integ_gain <= '0;
      deriv_gain <= '0;
      limit_low  <= {1'b1, {(LIMIT_W-1){1'b0}}};
      limit_high <= {1'b0, {(LIMIT_W-1){1'b1}}};
      mode_bits  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  prop_gain  <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN: integ_gain <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN: deriv_gain <= cfg_data[GAIN_W-1:0];
        REG_LIMIT_LOW:  limit_low  <= cfg_data[LIMIT_W-1:0];
        REG_LIMIT_HIGH: limit_high <= cfg_data[LIMIT_W-1:0];
        REG_MODE_BITS:  mode_bits  <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Controller state and pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      integrator    <= '0;
      prev_measured <= '0;
      prev_err      <= '0;
      s1_valid      <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (s_accept) begin
        integrator    <= integrator_next;
        prev_measured <= meas_in;
        // Previous error tracks only while zero-cross reset is enabled.
        if (mode_bits[MODE_ZERO_CROSS]) begin
          prev_err <= err_in;
        end
      end

      if (s_accept) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_err   <= err_in;
      s1_dmeas <= dmeas_next;
      s1_integ <= integrator_next;
    end
    if (out_load) begin
      correction <= correction_next;
    end
  end

  assign m_tdata = correction;

`ifndef SYNTHESIS
  // A filled input stage always reaches an empty result register next cycle.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !m_tvalid |=> m_tvalid)
    else $error("input stage did not advance into empty result register");

  // Zero-cross reset clears the integrator on a rising sign change.
  assert property (@(posedge clk) disable iff (rst)
    s_accept && mode_bits[MODE_ZERO_CROSS] && (err_in > 0) && (prev_err <= 0)
    |=> integrator == 0)
    else $error("integrator not cleared on error sign change");

  // Integrator clamp keeps the state inside ordered limits while zero-cross reset is off.
  assert property (@(posedge clk) disable iff (rst)
    s_accept && mode_bits[MODE_CLAMP_INTEG] && !mode_bits[MODE_ZERO_CROSS]
    && (limit_low <= limit_high)
    |=> (integrator >= $past(limit_low)) && (integrator <= $past(limit_high)))
    else $error("integrator outside clamp limits");

  // Output clamp keeps a loaded correction inside ordered limits.
  assert property (@(posedge clk) disable iff (rst)
    out_load && mode_bits[MODE_CLAMP_OUT] && (limit_low <= limit_high)
    |=> (correction >= $past(limit_low)) && (correction <= $past(limit_high)))
    else $error("correction outside clamp limits");
`endif

endmodule
